// ----- sv/ympr_pkg.sv -----
// Package with the shared types, codes and constants of the YMODEM packet receiver.
package ympr_pkg;

  // Payload lengths selected by the start byte.
  localparam int unsigned SHORT_PAYLOAD = 128;
  localparam int unsigned LONG_PAYLOAD  = 1024;

  // Timeout limit after reset, in ticks.
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // Control bytes of the protocol.
  localparam logic [7:0] BYTE_SOH     = 8'h01;
  localparam logic [7:0] BYTE_STX     = 8'h02;
  localparam logic [7:0] BYTE_EOT     = 8'h04;
  localparam logic [7:0] BYTE_CAN     = 8'h18;
  localparam logic [7:0] BYTE_UPPER_C = 8'h43;
  localparam logic [7:0] BYTE_UPPER_A = 8'h41;
  localparam logic [7:0] BYTE_LOWER_A = 8'h61;

  // CRC-16/XMODEM polynomial.
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } ympr_op_t;

  typedef enum logic {
    RK_DATA   = 1'b0,
    RK_STATUS = 1'b1
  } ympr_kind_t;

  typedef enum logic [2:0] {
    ST_GOOD    = 3'd0,
    ST_EOT     = 3'd1,
    ST_CANCEL  = 3'd2,
    ST_ABORT   = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_STRAY   = 3'd5
  } ympr_status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_CAN    = 2'd1,
    PH_PACKET = 2'd2
  } ympr_phase_t;

  typedef struct packed {
    ympr_op_t   operation;
    logic [7:0] byte_value;
  } ympr_item_t;

  typedef struct packed {
    ympr_kind_t   result_kind;
    logic [7:0]   data_byte;
    ympr_status_t packet_status;
    logic         long_packet;
    logic [7:0]   seq_number;
  } ympr_result_t;

endpackage

// ----- sv/ympr_ifs.sv -----
// Channel interfaces of the YMODEM packet receiver: input, result and configuration.
interface ympr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] byte_value;

  modport source (output valid, output operation, output byte_value, input ready);
  modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

interface ympr_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] data_byte;
  logic [2:0] packet_status;
  logic       long_packet;
  logic [7:0] seq_number;

  modport source (output valid, output result_kind, output data_byte, output packet_status,
                  output long_packet, output seq_number, input ready);
  modport sink   (input valid, input result_kind, input data_byte, input packet_status,
                  input long_packet, input seq_number, output ready);
endinterface

interface ympr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;

  modport source (output valid, output timeout_ticks, input ready);
  modport sink   (input valid, input timeout_ticks, output ready);
endinterface

// ----- sv/ympr_in_stage.sv -----
// Input register that holds one accepted item until the core consumes it.
module ympr_in_stage import ympr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ympr_item_t in_item,
  input  logic       take,
  output logic       held_valid,
  output ympr_item_t held_item
);

  logic       valid_r;
  logic       valid_nxt;
  ympr_item_t item_r;

  // The register can load whenever it is empty or being emptied this cycle.
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

// ----- sv/ympr_core.sv -----
// Packet state machine with CRC, sequence check and tick timeout for one item per cycle while fire is high.
module ympr_core import ympr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  ympr_item_t   item,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_data,
  output logic         res_valid,
  output ympr_result_t res
);

  localparam logic [10:0] SHORT_LAST = 11'(SHORT_PAYLOAD + 1);
  localparam logic [10:0] LONG_LAST  = 11'(LONG_PAYLOAD + 1);

  ympr_phase_t phase_r, phase_nxt;
  logic [10:0] pos_r, pos_nxt;
  logic        long_r, long_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  comp_r, comp_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [15:0] timeout_r;

  logic [15:0]  crc_upd;
  logic [15:0]  limit;
  logic [16:0]  tick_sum;
  logic [10:0]  last_payload;
  logic         emit;
  ympr_status_t emit_code;
  logic         emit_long;
  logic [7:0]   emit_seq;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  assign crc_upd      = crc_byte(crc_r, item.byte_value);
  // A zero limit behaves as one tick.
  assign limit        = (timeout_r == 16'd0) ? 16'd1 : timeout_r;
  assign tick_sum     = {1'b0, idle_r} + 17'd1;
  assign last_payload = long_r ? LONG_LAST : SHORT_LAST;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    long_nxt  = long_r;
    seq_nxt   = seq_r;
    comp_nxt  = comp_r;
    crc_nxt   = crc_r;
    idle_nxt  = idle_r;
    emit      = 1'b0;
    emit_code = ST_GOOD;
    emit_long = 1'b0;
    emit_seq  = 8'h00;
    res_valid = 1'b0;
    res.result_kind   = RK_DATA;
    res.data_byte     = item.byte_value;
    res.packet_status = ST_GOOD;
    res.long_packet   = long_r;
    res.seq_number    = seq_r;

    if (item.operation == OP_TICK) begin
      idle_nxt = tick_sum[15:0];
      if (tick_sum >= {1'b0, limit}) begin
        emit      = 1'b1;
        emit_code = (phase_r == PH_CAN) ? ST_ABORT : ST_TIMEOUT;
      end
    end else begin
      idle_nxt = 16'd0;
      unique case (phase_r)
        PH_CAN: begin
          emit      = 1'b1;
          emit_code = (item.byte_value == BYTE_CAN) ? ST_CANCEL : ST_ABORT;
        end
        PH_PACKET: begin
          pos_nxt = pos_r + 11'd1;
          priority if (pos_r == 11'd0) begin
            seq_nxt = item.byte_value;
          end else if (pos_r == 11'd1) begin
            comp_nxt = item.byte_value;
          end else begin
            crc_nxt = crc_upd;
            priority if (pos_r <= last_payload) begin
              res_valid = 1'b1;
            end else if (pos_r == last_payload + 11'd1) begin
              // First trailer byte only feeds the CRC.
            end else begin
              emit      = 1'b1;
              emit_code = ((seq_r == ~comp_r) && (crc_upd == 16'd0)) ? ST_GOOD : ST_ABORT;
              emit_long = long_r;
              emit_seq  = seq_r;
            end
          end
        end
        default: begin
          unique case (item.byte_value)
            BYTE_SOH, BYTE_STX: begin
              long_nxt  = (item.byte_value == BYTE_STX);
              phase_nxt = PH_PACKET;
              pos_nxt   = 11'd0;
              crc_nxt   = 16'd0;
              seq_nxt   = 8'h00;
              comp_nxt  = 8'h00;
            end
            BYTE_EOT: begin
              emit      = 1'b1;
              emit_code = ST_EOT;
            end
            BYTE_CAN: begin
              phase_nxt = PH_CAN;
            end
            BYTE_UPPER_C, BYTE_UPPER_A, BYTE_LOWER_A: begin
              emit      = 1'b1;
              emit_code = ST_ABORT;
            end
            default: begin
              emit      = 1'b1;
              emit_code = ST_STRAY;
            end
          endcase
        end
      endcase
    end

    // Every status returns the receiver to idle.
    if (emit) begin
      res_valid         = 1'b1;
      res.result_kind   = RK_STATUS;
      res.data_byte     = 8'h00;
      res.packet_status = emit_code;
      res.long_packet   = emit_long;
      res.seq_number    = emit_seq;
      phase_nxt         = PH_IDLE;
      pos_nxt           = 11'd0;
      idle_nxt          = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= 11'd0;
      long_r  <= 1'b0;
      seq_r   <= 8'h00;
      comp_r  <= 8'h00;
      crc_r   <= 16'd0;
      idle_r  <= 16'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      long_r  <= long_nxt;
      seq_r   <= seq_nxt;
      comp_r  <= comp_nxt;
      crc_r   <= crc_nxt;
      idle_r  <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_data;
    end
  end

endmodule

// ----- sv/ympr_out_stage.sv -----
// Result register that holds one result until the downstream side takes it.
module ympr_out_stage import ympr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  ympr_result_t res,
  output logic         free,
  output logic         out_valid,
  input  logic         out_ready,
  output ympr_result_t out_res
);

  logic         valid_r;
  logic         valid_nxt;
  ympr_result_t res_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- sv/ymodem_packet_receiver_top.sv -----
// Top level of the YMODEM packet receiver with CRC-16/XMODEM check.
//
//   Channel  Direction  Payload                                          Handshake
//   in_ch    sink       operation, byte_value                            valid/ready
//   out_ch   source     result_kind, data_byte, packet_status,           valid/ready
//                       long_packet, seq_number
//   cfg_ch   sink       timeout_ticks                                    valid/ready
//
// One item is accepted per clock cycle while the output is not stalled. An item is held in the input register,
// processed by the packet state machine and CRC update once the result register can take a result, and
// its result, if any, passes through the result register to out_ch; the byte-wide CRC step sets the
// critical path. Reset (synchronous, rst_n low) returns the receiver to idle and loads
// the timeout limit with 1000 ticks. A stalled output holds its item, and the input
// register keeps accepting as long as the item it holds can move forward.
module ymodem_packet_receiver_top import ympr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ympr_in_if.sink    in_ch,
  ympr_out_if.source out_ch,
  ympr_cfg_if.sink   cfg_ch
);

  ympr_item_t   in_item;
  ympr_item_t   held_item;
  logic         held_valid;
  logic         out_free;
  logic         fire;
  logic         res_valid;
  ympr_result_t res;
  ympr_result_t out_res;
  logic         out_valid;

  assign in_item.operation  = ympr_op_t'(in_ch.operation);
  assign in_item.byte_value = in_ch.byte_value;

  // The held item is processed whenever the result register can take a result.
  assign fire = held_valid && out_free;

  ympr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .take       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // Configuration writes are always taken; the user must write only while the block is idle, which it does not enforce.
  assign cfg_ch.ready = 1'b1;

  ympr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (held_item),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.timeout_ticks),
    .res_valid (res_valid),
    .res       (res)
  );

  ympr_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.result_kind   = out_res.result_kind;
  assign out_ch.data_byte     = out_res.data_byte;
  assign out_ch.packet_status = out_res.packet_status;
  assign out_ch.long_packet   = out_res.long_packet;
  assign out_ch.seq_number    = out_res.seq_number;

endmodule

// ----- sv/ympr_checker.sv -----
// Port-level checker of the YMODEM packet receiver and its binding to the top level.
module ympr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       result_kind,
  input logic [7:0] data_byte,
  input logic [2:0] packet_status,
  input logic       long_packet,
  input logic [7:0] seq_number
);

  // The input side only blocks while a result waits at a stalled output.
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input blocked without a stalled result");

  // A result appearing on an empty output comes from an item accepted earlier, via the input and result registers.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching accepted item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(result_kind) && $stable(data_byte) &&
      $stable(packet_status) && $stable(long_packet) && $stable(seq_number)))
    else $error("stalled result changed");

endmodule

bind ymodem_packet_receiver_top ympr_checker u_ympr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .result_kind   (out_ch.result_kind),
  .data_byte     (out_ch.data_byte),
  .packet_status (out_ch.packet_status),
  .long_packet   (out_ch.long_packet),
  .seq_number    (out_ch.seq_number)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the YMODEM packet receiver with CRC-16/XMODEM check.
`timescale 1ns / 1ps

module testbench;
  import ympr_pkg::*;

  // The receiver may hold off longer than any sender gap, so the watchdog is set
  // well above the longest deliberate hold-off.
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned LONG_HOLD    = 500;
  localparam int unsigned HOLD_TRIGGER = 100;
  // Results pass through the input register and the result register; the drain count leaves margin for items that
  // cause no result while the block finishes them.
  localparam int unsigned DRAIN_CYCLES = 8;

  // Ways in which a generated packet may be damaged.
  typedef enum int unsigned {
    FLAW_NONE,
    FLAW_COMP,
    FLAW_CRC,
    FLAW_CUT
  } flaw_t;

  logic clk;
  logic rst_n;

  ympr_in_if  in_ch();
  ympr_out_if out_ch();
  ympr_cfg_if cfg_ch();

  ymodem_packet_receiver_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Stimulus and expectation stores.
  ympr_item_t   pending_items[$];
  ympr_result_t decoded_due[$];
  logic [15:0]  timeout_writes[$];
  ympr_item_t   cur_item;

  int unsigned items_queued;
  int unsigned items_accepted;
  int unsigned writes_requested;
  int unsigned writes_done;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned quiet_cycles;

  // Flow control state of the driver and the monitor.
  bit          no_gaps;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;

  // Our own copy of the receiver state, advanced once per accepted item.
  logic [15:0] tmo_limit;
  ympr_phase_t rx_phase;
  logic [10:0] rx_pos;
  logic        rx_long;
  logic [7:0]  rx_seq;
  logic [7:0]  rx_comp;
  logic [15:0] rx_crc;
  logic [16:0] idle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One MSB-first CRC-16/XMODEM step over a byte.
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // A status always ends the current exchange and sends the receiver back to idle.
  function automatic void push_status(ympr_status_t st, logic lng, logic [7:0] sq);
    ympr_result_t r;
    r.result_kind   = RK_STATUS;
    r.data_byte     = 8'h00;
    r.packet_status = st;
    r.long_packet   = lng;
    r.seq_number    = sq;
    decoded_due.push_back(r);
    rx_phase = PH_IDLE;
    rx_pos   = '0;
    idle_cnt = '0;
  endfunction

  // Decodes one accepted item and records the result it must cause, if any.
  function automatic void decode_item(ympr_item_t it);
    ympr_result_t r;
    logic [15:0]  lim;
    logic [10:0]  pos;
    int unsigned  plen;
    logic [7:0]   b;
    b = it.byte_value;
    if (it.operation == OP_TICK) begin
      // A zero limit behaves as a limit of one tick.
      lim = (tmo_limit == 16'd0) ? 16'd1 : tmo_limit;
      idle_cnt = idle_cnt + 17'd1;
      if (idle_cnt >= {1'b0, lim}) begin
        // Running out of ticks after a lone CAN counts as an abort.
        push_status((rx_phase == PH_CAN) ? ST_ABORT : ST_TIMEOUT, 1'b0, 8'h00);
      end
      return;
    end
    idle_cnt = '0;
    case (rx_phase)
      PH_CAN: begin
        push_status((b == BYTE_CAN) ? ST_CANCEL : ST_ABORT, 1'b0, 8'h00);
      end
      PH_PACKET: begin
        plen = rx_long ? LONG_PAYLOAD : SHORT_PAYLOAD;
        pos = rx_pos;
        rx_pos = rx_pos + 11'd1;
        if (pos == 11'd0) begin
          rx_seq = b;
        end else if (pos == 11'd1) begin
          rx_comp = b;
        end else begin
          rx_crc = crc16_step(rx_crc, b);
          if (pos < plen + 2) begin
            r.result_kind   = RK_DATA;
            r.data_byte     = b;
            r.packet_status = ST_GOOD;
            r.long_packet   = rx_long;
            r.seq_number    = rx_seq;
            decoded_due.push_back(r);
          end else if (pos >= plen + 3) begin
            // Last trailer byte: the sequence pair and the CRC remainder decide.
            push_status((rx_seq == ~rx_comp && rx_crc == 16'h0000) ? ST_GOOD : ST_ABORT,
                        rx_long, rx_seq);
          end
        end
      end
      default: begin
        case (b)
          BYTE_SOH, BYTE_STX: begin
            rx_long  = (b == BYTE_STX);
            rx_phase = PH_PACKET;
            rx_pos   = '0;
            rx_crc   = '0;
            rx_seq   = '0;
            rx_comp  = '0;
          end
          BYTE_EOT: push_status(ST_EOT, 1'b0, 8'h00);
          BYTE_CAN: rx_phase = PH_CAN;
          BYTE_UPPER_C, BYTE_UPPER_A, BYTE_LOWER_A: push_status(ST_ABORT, 1'b0, 8'h00);
          default: push_status(ST_STRAY, 1'b0, 8'h00);
        endcase
      end
    endcase
  endfunction

  // Gap lengths are mostly zero, sometimes short and now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Input driver. The predictor is advanced at the edge where an item is taken,
  // and a new item is only put on the channel once the previous one is gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    = 0;
      rx_phase    = PH_IDLE;
      rx_pos      = '0;
      rx_long     = 1'b0;
      rx_seq      = '0;
      rx_comp     = '0;
      rx_crc      = '0;
      idle_cnt    = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_item(cur_item);
        items_accepted++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.operation  <= cur_item.operation;
          in_ch.byte_value <= cur_item.byte_value;
          send_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Configuration driver. The limit in the predictor changes when the write is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
      tmo_limit    = TIMEOUT_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        tmo_limit = cfg_ch.timeout_ticks;
        writes_done++;
      end
      if (!(cfg_ch.valid && !cfg_ch.ready)) begin
        if (timeout_writes.size() > 0) begin
          cfg_ch.valid         <= 1'b1;
          cfg_ch.timeout_ticks <= timeout_writes.pop_front();
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Besides the random stalls it holds off once for a long stretch,
  // while the sender keeps offering items, so that the block backs up to its input.
  always @(posedge clk) begin
    ympr_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
      hold_left    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (decoded_due.size() == 0) begin
          $error("unexpected result: kind %0d byte %0d status %0d", out_ch.result_kind,
                 out_ch.data_byte, out_ch.packet_status);
          error_count++;
        end else begin
          want = decoded_due.pop_front();
          check_field("result_kind", want.result_kind, out_ch.result_kind);
          check_field("data_byte", want.data_byte, out_ch.data_byte);
          check_field("packet_status", want.packet_status, out_ch.packet_status);
          check_field("long_packet", want.long_packet, out_ch.long_packet);
          check_field("seq_number", want.seq_number, out_ch.seq_number);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_TRIGGER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_item(ympr_op_t op, logic [7:0] b);
    ympr_item_t it;
    it.operation  = op;
    it.byte_value = b;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_byte(logic [7:0] b);
    add_item(OP_BYTE, b);
  endtask

  // The byte lane of a tick is ignored by the block, so it carries noise.
  task automatic add_tick();
    add_item(OP_TICK, 8'($urandom));
  endtask

  // Waits until every item is taken and every expected result has come out, then
  // lets the block finish any item that causes no result.
  task automatic wait_idle();
    while (items_accepted != items_queued || decoded_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] value);
    wait_idle();
    timeout_writes.push_back(value);
    writes_requested++;
    while (writes_done != writes_requested) @(posedge clk);
  endtask

  // Queues one packet. Short runs of ticks below the limit may fall between bytes;
  // a cut packet is left to time out.
  task automatic add_packet(bit is_long, int unsigned tmo, flaw_t flaw);
    logic [7:0]  body[$];
    logic [7:0]  seq_b;
    logic [7:0]  comp_b;
    logic [15:0] crc;
    int unsigned plen;
    int unsigned keep;
    plen  = is_long ? LONG_PAYLOAD : SHORT_PAYLOAD;
    seq_b = 8'($urandom);
    comp_b = ~seq_b;
    if (flaw == FLAW_COMP) comp_b ^= 8'h01 << $urandom_range(0, 7);
    crc = '0;
    body.push_back(seq_b);
    body.push_back(comp_b);
    repeat (plen) begin
      body.push_back(8'($urandom));
      crc = crc16_step(crc, body[body.size() - 1]);
    end
    if (flaw == FLAW_CRC) crc ^= 16'h0001 << $urandom_range(0, 15);
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);
    keep = (flaw == FLAW_CUT) ? $urandom_range(0, body.size() - 1) : body.size();
    add_byte(is_long ? BYTE_STX : BYTE_SOH);
    for (int i = 0; i < keep; i++) begin
      if (tmo > 1 && $urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, (tmo - 1 < 4) ? tmo - 1 : 4)) add_tick();
      end
      add_byte(body[i]);
    end
    if (flaw == FLAW_CUT) repeat (tmo) add_tick();
  endtask

  // One random exchange. Packets make up the largest share; the rest is control traffic,
  // tick bursts, broken sequences and plain noise.
  task automatic add_random_exchange(int unsigned tmo);
    int unsigned sel;
    int unsigned f;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      f = $urandom_range(0, 9);
      if (f < 6) add_packet(1'b0, tmo, FLAW_NONE);
      else if (f < 7) add_packet(1'b0, tmo, FLAW_COMP);
      else if (f < 8) add_packet(1'b0, tmo, FLAW_CRC);
      else add_packet(1'b0, tmo, (tmo <= 50) ? FLAW_CUT : FLAW_CRC);
    end else if (sel < 55) begin
      add_byte(BYTE_EOT);
    end else if (sel < 62) begin
      add_byte(BYTE_CAN);
      add_byte(BYTE_CAN);
    end else if (sel < 67) begin
      add_byte(BYTE_CAN);
      add_byte(8'($urandom));
    end else if (sel < 72) begin
      add_byte(BYTE_CAN);
      if (tmo <= 50) repeat (tmo) add_tick();
      else add_byte(BYTE_EOT);
    end else if (sel < 78) begin
      case ($urandom_range(0, 2))
        0: add_byte(BYTE_UPPER_C);
        1: add_byte(BYTE_UPPER_A);
        default: add_byte(BYTE_LOWER_A);
      endcase
    end else if (sel < 84) begin
      add_byte(8'($urandom));
    end else if (sel < 92) begin
      repeat ($urandom_range(1, (tmo + 1 < 60) ? tmo + 1 : 60)) add_tick();
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1) != 0) add_tick();
        else add_byte(8'($urandom));
      end
    end
  endtask

  task automatic run_batch(logic [15:0] tmo, int unsigned count, bit quiet);
    int unsigned start;
    write_timeout(tmo);
    no_gaps = quiet;
    start = items_queued;
    while (items_queued - start < count) add_random_exchange(tmo);
  endtask

  initial begin
    // All block inputs are known from time zero.
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = 1'b0;
    in_ch.byte_value     = 8'h00;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.timeout_ticks = 16'h0000;
    items_queued     = 0;
    items_accepted   = 0;
    writes_requested = 0;
    writes_done      = 0;
    results_seen     = 0;
    error_count      = 0;
    quiet_cycles     = 0;
    no_gaps          = 1'b0;
    hold_done        = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset limit: ticks below the limit give nothing, then
    // every control byte but STX, the cancel pair, a lone CAN followed by another byte,
    // the three abort bytes and stray bytes at both ends of the range.
    repeat (3) add_tick();
    add_byte(BYTE_EOT);
    add_byte(BYTE_CAN);
    add_byte(BYTE_CAN);
    add_byte(BYTE_CAN);
    add_byte(8'h00);
    add_byte(BYTE_CAN);
    add_byte(BYTE_SOH);
    add_byte(BYTE_UPPER_C);
    add_byte(BYTE_UPPER_A);
    add_byte(BYTE_LOWER_A);
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(8'h03);

    // Smallest limit: a timeout while idle, after a lone CAN and inside a packet.
    write_timeout(16'd1);
    add_tick();
    add_byte(BYTE_CAN);
    add_tick();
    add_byte(BYTE_SOH);
    add_tick();
    add_byte(BYTE_STX);
    add_byte(8'h5a);
    add_tick();

    // A zero limit behaves as one tick.
    write_timeout(16'd0);
    add_tick();
    add_tick();

    write_timeout(16'd2);
    repeat (3) add_tick();

    // A long packet cut off inside its payload: the data items carry the long flag
    // and the timeout drops the rest.
    add_byte(BYTE_STX);
    add_byte(8'h3c);
    add_byte(8'hc3);
    repeat (40) add_byte(8'($urandom));
    repeat (2) add_tick();

    // Random part over several limits; the middle batch runs with no idling at all.
    run_batch(16'($urandom_range(3, 12)), 150, 1'b0);
    run_batch(16'd1000, 150, 1'b1);
    run_batch(16'($urandom_range(20, 200)), 150, 1'b0);

    // Largest limit: the ticks between the bytes of a packet stay far below it.
    write_timeout(16'hffff);
    no_gaps = 1'b0;
    add_packet(1'b0, 16'hffff, FLAW_NONE);
    add_byte(BYTE_EOT);

    wait_idle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ympr_pkg.sv
sv/ympr_ifs.sv
sv/ympr_in_stage.sv
sv/ympr_core.sv
sv/ympr_out_stage.sv
sv/ymodem_packet_receiver_top.sv
sv/ympr_checker.sv
tb/testbench.sv
